### hw/rtl/frhb_pkg.sv
`default_nettype none

package frhb_pkg;

  // field widths fixed by the port list
  localparam int SAMPLE_W   = 32;
  localparam int HALF_W     = 31;
  localparam int INV_W      = 32;
  localparam int SEL_W      = 10;
  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 48;
  localparam int TALLY_OUT_W = 11;

  // bin arithmetic: offset times reciprocal, top bits of the product
  localparam int PROD_W     = 64;
  localparam int PROD_SHIFT = 40;
  localparam int BIN_RAW_W  = PROD_W - PROD_SHIFT;

  // saturation limits
  localparam logic [COUNT_W-1:0]     COUNT_MAX     = '1;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX     = '1;
  localparam logic [TALLY_OUT_W-1:0] TALLY_OUT_MAX = '1;

  // sign bias for unsigned range compare
  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = 32'h8000_0000;

  // register reset values
  localparam logic [HALF_W-1:0] HALF_RANGE_RST    = 31'd16777216;
  localparam logic [INV_W-1:0]  INV_BIN_WIDTH_RST = 32'd33554432;

  // command codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic CFG_HALF_RANGE    = 1'b0;
  localparam logic CFG_INV_BIN_WIDTH = 1'b1;

  // queue between classifier and update engine
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = 3;
  localparam int PEND_W      = QUEUE_AW + 1;

  // what the update engine has to do with one entry
  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_READ,
    KIND_MISS,
    KIND_DROP
  } entry_kind_t;

  // back end status seen by the top level
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

### hw/rtl/fixed_range_histogram_binner.sv
`default_nettype none

// channel   direction  handshake                 payload
// command   in         start and not busy        opcode, sample, bin_select
// result    out        done, one cycle           bin_index, bin_count, total_samples,
//                                                nonempty_bins, out_of_range
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// Sustained rate is one command per cycle while busy is low; a result follows its
// command beat through three classifier stages, queue, bin read and update.
// At most six commands are in flight, below the eight queue credits; busy only marks clearing.
// After reset a clearing pass zeroes every bin of the store with busy high.
// Results cannot be stalled; done marks each result for one cycle.
module fixed_range_histogram_binner #(
  parameter int BIN_COUNT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              opcode,
  input  wire logic signed [frhb_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [frhb_pkg::SEL_W-1:0]        bin_select,
  output logic                                   done,
  output logic [frhb_pkg::IDX_W-1:0]             bin_index,
  output logic [frhb_pkg::COUNT_W-1:0]           bin_count,
  output logic [frhb_pkg::TOTAL_W-1:0]           total_samples,
  output logic [frhb_pkg::TALLY_OUT_W-1:0]       nonempty_bins,
  output logic                                   out_of_range,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [frhb_pkg::INV_W-1:0]        cfg_data
);

  localparam int BIN_W  = $clog2(BIN_COUNT);
  localparam int DATA_W = BIN_W + frhb_pkg::IDX_W;

  logic [frhb_pkg::HALF_W-1:0] half_range;
  logic [frhb_pkg::INV_W-1:0]  inv_bin_width;
  logic [frhb_pkg::PEND_W-1:0] pending;
  logic                        accept;

  logic                        push;
  frhb_pkg::entry_kind_t       push_kind;
  logic [BIN_W-1:0]            push_addr;
  logic [frhb_pkg::IDX_W-1:0]  push_idx;

  logic                        q_valid;
  frhb_pkg::entry_kind_t       q_kind;
  logic [DATA_W-1:0]           q_data;
  frhb_pkg::back_status_t      status;

  // command beat and credit check
  assign accept    = start && !busy;
  assign busy      = status.clearing ||
                     (pending == frhb_pkg::PEND_W'(frhb_pkg::QUEUE_DEPTH));
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_range    <= frhb_pkg::HALF_RANGE_RST;
      inv_bin_width <= frhb_pkg::INV_BIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        frhb_pkg::CFG_HALF_RANGE:    half_range    <= cfg_data[frhb_pkg::HALF_W-1:0];
        frhb_pkg::CFG_INV_BIN_WIDTH: inv_bin_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // commands accepted but not yet taken by the update engine
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({accept, status.pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  frhb_front #(
    .BIN_COUNT(BIN_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .sample       (sample),
    .bin_select   (bin_select),
    .half_range   (half_range),
    .inv_bin_width(inv_bin_width),
    .push         (push),
    .push_kind    (push_kind),
    .push_addr    (push_addr),
    .push_idx     (push_idx)
  );

  frhb_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_kind (push_kind),
    .in_data ({push_addr, push_idx}),
    .pop     (status.pop),
    .valid   (q_valid),
    .out_kind(q_kind),
    .out_data(q_data)
  );

  frhb_back #(
    .BIN_COUNT(BIN_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_kind   (q_kind),
    .q_addr   (q_data[DATA_W-1:frhb_pkg::IDX_W]),
    .q_idx    (q_data[frhb_pkg::IDX_W-1:0]),
    .status   (status),
    .res_valid(done),
    .res_idx  (bin_index),
    .res_count(bin_count),
    .res_total(total_samples),
    .res_tally(nonempty_bins),
    .res_oor  (out_of_range)
  );

endmodule

`default_nettype wire

### hw/rtl/frhb_front.sv
`default_nettype none

module frhb_front #(
  parameter int BIN_COUNT = 1024,
  localparam int BIN_W = $clog2(BIN_COUNT)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic                              opcode,
  input  wire logic [frhb_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic [frhb_pkg::SEL_W-1:0]        bin_select,
  input  wire logic [frhb_pkg::HALF_W-1:0]       half_range,
  input  wire logic [frhb_pkg::INV_W-1:0]        inv_bin_width,
  output logic                                   push,
  output frhb_pkg::entry_kind_t                  push_kind,
  output logic [BIN_W-1:0]                       push_addr,
  output logic [frhb_pkg::IDX_W-1:0]             push_idx
);

  localparam logic [16:0] BIN_COUNT_S = 17'(BIN_COUNT);
  localparam logic [frhb_pkg::BIN_RAW_W:0] BIN_COUNT_R = (frhb_pkg::BIN_RAW_W + 1)'(BIN_COUNT);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

  // stage 0: captured beat
  logic                          s0_valid;
  logic                          s0_op;
  logic [frhb_pkg::SAMPLE_W-1:0] s0_sample;
  logic [frhb_pkg::SEL_W-1:0]    s0_sel;

  // stage 1: classified beat
  logic                          s1_valid;
  frhb_pkg::entry_kind_t         s1_kind;
  logic [frhb_pkg::SAMPLE_W-1:0] s1_offset;
  logic [BIN_W-1:0]              s1_addr;
  logic [frhb_pkg::IDX_W-1:0]    s1_idx;

  // stage 2: product ready
  logic                          s2_valid;
  frhb_pkg::entry_kind_t         s2_kind;
  logic [frhb_pkg::PROD_W-1:0]   s2_prod;
  logic [BIN_W-1:0]              s2_addr;
  logic [frhb_pkg::IDX_W-1:0]    s2_idx;

  logic [frhb_pkg::SAMPLE_W-1:0]  biased;
  logic [frhb_pkg::SAMPLE_W-1:0]  low;
  logic [frhb_pkg::SAMPLE_W-1:0]  high;
  logic                           in_range;
  logic                           sel_miss;
  frhb_pkg::entry_kind_t          cls_kind;
  logic [frhb_pkg::BIN_RAW_W-1:0] bin_raw;
  logic                           bin_clamp;
  logic [BIN_W-1:0]               add_addr;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  // capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_op     <= opcode;
      s0_sample <= sample;
      s0_sel    <= bin_select;
    end
  end

  // range test on the biased sample, read bound test
  always_comb begin
    biased   = s0_sample ^ frhb_pkg::SIGN_BIAS;
    low      = frhb_pkg::SIGN_BIAS - {1'b0, half_range};
    high     = frhb_pkg::SIGN_BIAS + {1'b0, half_range};
    in_range = (biased >= low) && (biased <= high);
    sel_miss = {7'd0, s0_sel} >= BIN_COUNT_S;
    if (s0_op == frhb_pkg::OP_READ) begin
      cls_kind = sel_miss ? frhb_pkg::KIND_MISS : frhb_pkg::KIND_READ;
    end else begin
      cls_kind = in_range ? frhb_pkg::KIND_ADD : frhb_pkg::KIND_DROP;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind   <= cls_kind;
    s1_offset <= biased - low;
    s1_addr   <= BIN_W'(s0_sel);
    s1_idx    <= (s0_op == frhb_pkg::OP_READ) ? s0_sel : '0;
  end

  // scale the offset by the reciprocal bin width
  always_ff @(posedge clk) begin
    s2_kind <= s1_kind;
    s2_prod <= frhb_pkg::PROD_W'(s1_offset) * frhb_pkg::PROD_W'(inv_bin_width);
    s2_addr <= s1_addr;
    s2_idx  <= s1_idx;
  end

  // bin number and clamp to the last bin
  always_comb begin
    bin_raw   = s2_prod[frhb_pkg::PROD_W-1:frhb_pkg::PROD_SHIFT];
    bin_clamp = {1'b0, bin_raw} >= BIN_COUNT_R;
    add_addr  = bin_clamp ? BIN_LAST : BIN_W'(bin_raw);
    push      = s2_valid;
    push_kind = s2_kind;
    if (s2_kind == frhb_pkg::KIND_ADD) begin
      push_addr = add_addr;
      push_idx  = frhb_pkg::IDX_W'(add_addr);
    end else begin
      push_addr = s2_addr;
      push_idx  = s2_idx;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/frhb_queue.sv
`default_nettype none

module frhb_queue #(
  parameter int DATA_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire frhb_pkg::entry_kind_t in_kind,
  input  wire logic [DATA_W-1:0]     in_data,
  input  wire logic                  pop,
  output logic                       valid,
  output frhb_pkg::entry_kind_t      out_kind,
  output logic [DATA_W-1:0]          out_data
);

  frhb_pkg::entry_kind_t       kind_q [frhb_pkg::QUEUE_DEPTH];
  logic [DATA_W-1:0]           data_q [frhb_pkg::QUEUE_DEPTH];
  logic [frhb_pkg::QUEUE_AW-1:0] wptr;
  logic [frhb_pkg::QUEUE_AW-1:0] rptr;
  logic [frhb_pkg::PEND_W-1:0]   count;

  // pointers and fill level; upstream credit keeps it from overflowing
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_q[wptr] <= in_kind;
      data_q[wptr] <= in_data;
    end
  end

  // head of queue shown ahead of the pop
  assign valid    = (count != '0);
  assign out_kind = kind_q[rptr];
  assign out_data = data_q[rptr];

endmodule

`default_nettype wire

### hw/rtl/frhb_back.sv
`default_nettype none

module frhb_back #(
  parameter int BIN_COUNT = 1024,
  localparam int BIN_W = $clog2(BIN_COUNT)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire frhb_pkg::entry_kind_t             q_kind,
  input  wire logic [BIN_W-1:0]                  q_addr,
  input  wire logic [frhb_pkg::IDX_W-1:0]        q_idx,
  output frhb_pkg::back_status_t                 status,
  output logic                                   res_valid,
  output logic [frhb_pkg::IDX_W-1:0]             res_idx,
  output logic [frhb_pkg::COUNT_W-1:0]           res_count,
  output logic [frhb_pkg::TOTAL_W-1:0]           res_total,
  output logic [frhb_pkg::TALLY_OUT_W-1:0]       res_tally,
  output logic                                   res_oor
);

  localparam int TALLY_W = $clog2(BIN_COUNT + 1);
  localparam int TW = (TALLY_W > frhb_pkg::TALLY_OUT_W) ? TALLY_W : frhb_pkg::TALLY_OUT_W;
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

  logic [frhb_pkg::COUNT_W-1:0] mem [BIN_COUNT];
  logic [frhb_pkg::COUNT_W-1:0] rd_data;

  logic                         clr_active;
  logic [BIN_W-1:0]             clr_addr;

  logic                         b_valid;
  frhb_pkg::entry_kind_t        b_kind;
  logic [BIN_W-1:0]             b_addr;
  logic [frhb_pkg::IDX_W-1:0]   b_idx;
  logic                         b_fwd;
  logic [frhb_pkg::COUNT_W-1:0] b_fwd_val;

  logic [frhb_pkg::TOTAL_W-1:0] total;
  logic [TALLY_W-1:0]           tally;

  logic                         pop;
  logic                         is_add;
  logic [frhb_pkg::COUNT_W-1:0] old_cnt;
  logic [frhb_pkg::COUNT_W-1:0] new_cnt;
  logic [frhb_pkg::TOTAL_W-1:0] total_next;
  logic [TALLY_W-1:0]           tally_next;
  logic [TW-1:0]                tally_ext;
  logic                         mem_we;
  logic [BIN_W-1:0]             mem_wa;
  logic [frhb_pkg::COUNT_W-1:0] mem_wd;

  // pop whenever the queue has an entry and the clear pass is done
  assign pop             = q_valid && !clr_active;
  assign status.pop      = pop;
  assign status.clearing = clr_active;

  // read-modify-write of the bin, with forwarding of the last write
  always_comb begin
    is_add     = b_valid && (b_kind == frhb_pkg::KIND_ADD);
    old_cnt    = b_fwd ? b_fwd_val : rd_data;
    new_cnt    = (old_cnt == frhb_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
    total_next = (is_add && (total != frhb_pkg::TOTAL_MAX)) ? total + 1'b1 : total;
    tally_next = (is_add && (old_cnt == '0)) ? tally + 1'b1 : tally;
    tally_ext  = TW'(tally_next);
    mem_we     = clr_active || is_add;
    mem_wa     = clr_active ? clr_addr : b_addr;
    mem_wd     = clr_active ? '0 : new_cnt;
  end

  // bin store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (pop)    rd_data     <= mem[q_addr];
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BIN_LAST) clr_active <= 1'b0;
    end
  end

  // update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      res_valid <= 1'b0;
      total     <= '0;
      tally     <= '0;
    end else begin
      b_valid   <= pop;
      res_valid <= b_valid;
      total     <= total_next;
      tally     <= tally_next;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      b_kind    <= q_kind;
      b_addr    <= q_addr;
      b_idx     <= q_idx;
      b_fwd     <= is_add && (b_addr == q_addr);
      b_fwd_val <= new_cnt;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    res_idx   <= b_idx;
    res_total <= total_next;
    res_tally <= (tally_ext > TW'(frhb_pkg::TALLY_OUT_MAX)) ?
                 frhb_pkg::TALLY_OUT_MAX : frhb_pkg::TALLY_OUT_W'(tally_ext);
    res_oor   <= (b_kind == frhb_pkg::KIND_DROP);
    case (b_kind)
      frhb_pkg::KIND_ADD:  res_count <= new_cnt;
      frhb_pkg::KIND_READ: res_count <= old_cnt;
      default:             res_count <= '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/frhb_checker.sv
`default_nettype none

module frhb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic [frhb_pkg::IDX_W-1:0]        bin_index,
  input wire logic [frhb_pkg::COUNT_W-1:0]      bin_count,
  input wire logic [frhb_pkg::TOTAL_W-1:0]      total_samples,
  input wire logic [frhb_pkg::TALLY_OUT_W-1:0]  nonempty_bins,
  input wire logic                              out_of_range
);

  // no result beat right after reset
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  // the clearing pass holds off commands after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy right after reset");

  // a dropped sample reports bin zero with count zero
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (bin_index == '0 && bin_count == '0))
    else $error("dropped sample reports a bin");

  // with every bin empty no bin can show a count
  a_empty_tally: assert property (@(posedge clk) disable iff (rst)
    (done && nonempty_bins == '0) |-> (bin_count == '0))
    else $error("count seen while no bin is occupied");

  // with no sample counted no bin can show a count
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (done && total_samples == '0) |-> (bin_count == '0))
    else $error("count seen while total is zero");

endmodule

bind fixed_range_histogram_binner frhb_checker u_frhb_checker (.*);

`default_nettype wire
